### rtl/i2c_ram_pkg.sv
package i2c_ram_pkg;

  localparam logic [5:0] STEP_IDLE = 6'd63;

  localparam logic [6:0]  DEV_ADDR_RST  = 7'd104;
  localparam logic [15:0] DELAY_RST     = 16'd10;

  localparam logic [3:0] WR_PLAN_LEN = 4'd8;
  localparam logic [3:0] RD_PLAN_LEN = 4'd10;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // APB register map, indexed by paddr[2]
  localparam logic REG_DEV_ADDR = 1'b0;
  localparam logic REG_DELAY    = 1'b1;

  typedef enum logic [2:0] {
    K_START  = 3'd0,
    K_ADDR_W = 3'd1,
    K_ADDR_R = 3'd2,
    K_REG    = 3'd3,
    K_DATA   = 3'd4,
    K_WACK   = 3'd5,
    K_READ   = 3'd6,
    K_STOP   = 3'd7
  } seg_kind_t;

  function automatic seg_kind_t seg_kind(input logic rd, input logic [3:0] seg);
    seg_kind_t k;
    k = K_STOP;
    if (rd) begin
      case (seg)
        4'd0:    k = K_START;
        4'd1:    k = K_ADDR_W;
        4'd2:    k = K_WACK;
        4'd3:    k = K_REG;
        4'd4:    k = K_WACK;
        4'd5:    k = K_START;
        4'd6:    k = K_ADDR_R;
        4'd7:    k = K_WACK;
        4'd8:    k = K_READ;
        default: k = K_STOP;
      endcase
    end else begin
      case (seg)
        4'd0:    k = K_START;
        4'd1:    k = K_ADDR_W;
        4'd2:    k = K_WACK;
        4'd3:    k = K_REG;
        4'd4:    k = K_WACK;
        4'd5:    k = K_DATA;
        4'd6:    k = K_WACK;
        default: k = K_STOP;
      endcase
    end
    return k;
  endfunction

endpackage

### rtl/i2c_ram_if.sv
interface i2c_cmd_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic       req_type;
  logic [7:0] reg_addr;
  logic [7:0] write_data;
  logic [7:0] read_len;
  logic       sda_in;

  modport source (output valid, cmd_valid, req_type, reg_addr, write_data, read_len, sda_in,
                  input ready);
  modport sink   (input valid, cmd_valid, req_type, reg_addr, write_data, read_len, sda_in,
                  output ready);
endinterface

interface i2c_rsp_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       rd_valid;
  logic [7:0] rd_data;
  logic       rd_last;
  logic       nack_seen;
  logic       done_res;

  modport source (output valid, scl_out, sda_out, busy_res, rd_valid, rd_data, rd_last,
                  nack_seen, done_res, input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, rd_valid, rd_data, rd_last,
                  nack_seen, done_res, output ready);
endinterface

### rtl/i2c_register_access_master.sv
// I2C register-access master, open-drain, stepped by a base tick.
// cmd (sink): one item per base tick. With cmd_valid set while idle it starts a
//   transaction: req_type 0 writes write_data to reg_addr, req_type 1 reads
//   read_len bytes from reg_addr through a repeated start. sda_in is the
//   sampled SDA level for that tick.
// rsp (source): one item per accepted cmd item, carrying the SCL/SDA drive
//   levels after the tick, busy, received bytes (rd_valid/rd_data/rd_last),
//   the sticky NACK flag and the done pulse at the end of STOP.
// APB port: device_address at 0x0, delay_ticks at 0x4 (ticks per bus delay).
//   Write only while no transaction runs.
// Timing: each item passes through the tick logic into the rsp register, so
//   its result appears in the cycle after acceptance. One item is accepted every
//   cycle while rsp is taken; the rsp register is the only stage.
// Stall: when rsp holds an item that is not taken, cmd.ready drops and the
//   sequencer does not advance; no tick is lost.
// Reset: sequencer idle, both lines released, flags clear, registers back to
//   address 0x68 and 10 ticks per delay; rsp holds no item.
module i2c_register_access_master
  import i2c_ram_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  i2c_cmd_if.sink     cmd,
  i2c_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0]  device_address;
  logic [15:0] delay_ticks;

  logic [5:0]  step;
  logic [3:0]  bit_count;
  logic [7:0]  shift_byte;
  logic [7:0]  bytes_left;
  logic [15:0] delay_count;
  logic        lr_rd;
  logic [7:0]  lr_reg;
  logic [7:0]  lr_data;
  logic [7:0]  lr_len;
  logic        line_scl;
  logic        line_sda;
  logic        nack_flag;
  logic [3:0]  seg_ptr;

  logic [5:0]  step_next;
  logic [3:0]  bit_count_next;
  logic [7:0]  shift_byte_next;
  logic [7:0]  bytes_left_next;
  logic [15:0] delay_count_next;
  logic        lr_rd_next;
  logic [7:0]  lr_reg_next;
  logic [7:0]  lr_data_next;
  logic [7:0]  lr_len_next;
  logic        line_scl_next;
  logic        line_sda_next;
  logic        nack_flag_next;
  logic [3:0]  seg_ptr_next;

  logic        busy_c;
  logic        rdv_c;
  logic [7:0]  rdd_c;
  logic        rdl_c;
  logic        done_c;

  logic        out_valid;
  logic        out_scl;
  logic        out_sda;
  logic        out_busy;
  logic        out_rdv;
  logic [7:0]  out_rdd;
  logic        out_rdl;
  logic        out_nack;
  logic        out_done;

  logic        accept;
  logic        cfg_wr;

  seg_kind_t   kind;
  seg_kind_t   kind_e;
  logic [15:0] delay_eff;
  logic [15:0] delay_cur;
  logic [15:0] delay_dec;
  logic        delay_done;
  logic        fin;
  logic        adv;
  logic [3:0]  seg_e;
  logic [7:0]  shift_rx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_DELAY) ? {16'd0, delay_ticks} : {25'd0, device_address};

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEV_ADDR_RST;
      delay_ticks    <= DELAY_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_DEV_ADDR) device_address <= pwdata[6:0];
      else                          delay_ticks    <= pwdata[15:0];
    end
  end

  assign cmd.ready = !out_valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;

  assign delay_eff = (delay_ticks == 16'd0) ? 16'd1 : delay_ticks;

  always_comb begin
    step_next        = step;
    bit_count_next   = bit_count;
    shift_byte_next  = shift_byte;
    bytes_left_next  = bytes_left;
    delay_count_next = delay_count;
    lr_rd_next       = lr_rd;
    lr_reg_next      = lr_reg;
    lr_data_next     = lr_data;
    lr_len_next      = lr_len;
    line_scl_next    = line_scl;
    line_sda_next    = line_sda;
    nack_flag_next   = nack_flag;
    seg_ptr_next     = seg_ptr;
    busy_c = 1'b0;
    rdv_c  = 1'b0;
    rdd_c  = 8'd0;
    rdl_c  = 1'b0;
    done_c = 1'b0;
    fin    = 1'b0;
    adv    = 1'b0;
    seg_e  = 4'd0;
    kind_e = K_STOP;
    shift_rx = 8'd0;

    // latch a new request; the first segment (START) begins on this tick
    if (step == STEP_IDLE && cmd.cmd_valid) begin
      lr_rd_next       = cmd.req_type;
      lr_reg_next      = cmd.reg_addr;
      lr_data_next     = cmd.write_data;
      lr_len_next      = cmd.read_len;
      nack_flag_next   = 1'b0;
      seg_ptr_next     = 4'd0;
      step_next        = 6'd0;
      bit_count_next   = 4'd0;
      delay_count_next = 16'd0;
    end

    kind       = seg_kind(lr_rd_next, seg_ptr_next);
    delay_cur  = (delay_count_next == 16'd0) ? delay_eff : delay_count_next;
    delay_dec  = delay_cur - 16'd1;
    delay_done = (delay_dec == 16'd0);

    if (step_next != STEP_IDLE) begin
      busy_c = 1'b1;
      case (kind)
        K_START: begin
          if (step_next == 6'd0) begin
            line_sda_next = 1'b1; adv = 1'b1;
          end else if (step_next == 6'd1) begin
            line_scl_next = 1'b1; adv = 1'b1;
          end else if (step_next == 6'd2 || step_next == 6'd4) begin
            delay_count_next = delay_dec;
            adv = delay_done;
          end else if (step_next == 6'd3) begin
            line_sda_next = 1'b0; adv = 1'b1;
          end else begin
            line_scl_next = 1'b0; fin = 1'b1;
          end
        end
        K_WACK: begin
          if (step_next == 6'd0) begin
            line_sda_next = 1'b1; adv = 1'b1;
          end else if (step_next == 6'd2) begin
            line_scl_next = 1'b1; adv = 1'b1;
          end else if (step_next == 6'd4) begin
            if (cmd.sda_in) nack_flag_next = 1'b1;
            line_scl_next = 1'b0; adv = 1'b1;
          end else begin
            delay_count_next = delay_dec;
            if (delay_done) begin
              if (step_next >= 6'd5) fin = 1'b1;
              else                   adv = 1'b1;
            end
          end
        end
        K_STOP: begin
          if (step_next == 6'd0) begin
            line_sda_next = 1'b0; adv = 1'b1;
          end else if (step_next == 6'd1) begin
            line_scl_next = 1'b1; adv = 1'b1;
          end else if (step_next == 6'd3) begin
            line_sda_next = 1'b1; adv = 1'b1;
          end else begin
            delay_count_next = delay_dec;
            if (delay_done) begin
              if (step_next >= 6'd4) fin = 1'b1;
              else                   adv = 1'b1;
            end
          end
        end
        K_READ: begin
          if (step_next == 6'd0) begin
            line_sda_next   = 1'b1;
            shift_byte_next = 8'd0;
            bit_count_next  = 4'd0;
            adv = 1'b1;
          end else if (step_next == 6'd1 || step_next == 6'd7 || step_next == 6'd13) begin
            line_scl_next = 1'b1; adv = 1'b1;
          end else if (step_next == 6'd3) begin
            // sample on the falling SCL edge
            shift_rx        = {shift_byte_next[6:0], cmd.sda_in};
            shift_byte_next = shift_rx;
            line_scl_next   = 1'b0;
            bit_count_next  = bit_count_next + 4'd1;
            if (bit_count_next >= BITS_PER_BYTE) begin
              rdv_c = 1'b1;
              rdd_c = shift_rx;
              rdl_c = (bytes_left_next == 8'd1);
            end
            adv = 1'b1;
          end else if (step_next == 6'd4) begin
            delay_count_next = delay_dec;
            if (delay_done) begin
              if (bit_count_next < BITS_PER_BYTE) step_next = 6'd1;
              else if (bytes_left_next > 8'd1)    step_next = 6'd5;
              else                                step_next = 6'd11;
            end
          end else if (step_next == 6'd5) begin
            line_sda_next = 1'b0; adv = 1'b1;
          end else if (step_next == 6'd9) begin
            line_scl_next = 1'b0; adv = 1'b1;
          end else if (step_next == 6'd11) begin
            line_sda_next = 1'b1; adv = 1'b1;
          end else if (step_next == 6'd10 || step_next >= 6'd15) begin
            // end of the ACK or NACK clock: next byte or leave
            if (step_next == 6'd10) line_sda_next = 1'b1;
            else                    line_scl_next = 1'b0;
            bytes_left_next = bytes_left_next - 8'd1;
            if (bytes_left_next == 8'd0) fin = 1'b1;
            else                         step_next = 6'd0;
          end else begin
            delay_count_next = delay_dec;
            adv = delay_done;
          end
        end
        default: begin
          // byte send: address, register or data
          if (step_next == 6'd0) begin
            line_sda_next   = shift_byte_next[7];
            shift_byte_next = {shift_byte_next[6:0], 1'b0};
            adv = 1'b1;
          end else if (step_next == 6'd2) begin
            line_scl_next = 1'b1; adv = 1'b1;
          end else if (step_next == 6'd4) begin
            line_scl_next = 1'b0; adv = 1'b1;
          end else if (step_next == 6'd1 || step_next == 6'd3 || step_next == 6'd5) begin
            delay_count_next = delay_dec;
            if (delay_done) begin
              if (step_next == 6'd5) begin
                bit_count_next = bit_count_next + 4'd1;
                step_next = (bit_count_next < BITS_PER_BYTE) ? 6'd0 : 6'd6;
              end else begin
                adv = 1'b1;
              end
            end
          end else begin
            line_sda_next = 1'b1; fin = 1'b1;
          end
        end
      endcase

      if (adv) step_next = step_next + 6'd1;

      // advance to the next segment, skipping an empty read
      if (fin) begin
        seg_e = seg_ptr_next + 4'd1;
        if (seg_e >= (lr_rd_next ? RD_PLAN_LEN : WR_PLAN_LEN)) begin
          step_next    = STEP_IDLE;
          seg_ptr_next = seg_e;
          done_c       = 1'b1;
        end else begin
          kind_e           = seg_kind(lr_rd_next, seg_e);
          step_next        = 6'd0;
          bit_count_next   = 4'd0;
          delay_count_next = 16'd0;
          case (kind_e)
            K_ADDR_W: shift_byte_next = {device_address, 1'b0};
            K_ADDR_R: shift_byte_next = {device_address, 1'b1};
            K_REG:    shift_byte_next = lr_reg_next;
            K_DATA:   shift_byte_next = lr_data_next;
            K_READ: begin
              bytes_left_next = lr_len_next;
              if (lr_len_next == 8'd0) seg_e = seg_e + 4'd1;
            end
            default: ;
          endcase
          seg_ptr_next = seg_e;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= STEP_IDLE;
      bit_count   <= 4'd0;
      shift_byte  <= 8'd0;
      bytes_left  <= 8'd0;
      delay_count <= 16'd0;
      lr_rd       <= 1'b0;
      lr_reg      <= 8'd0;
      lr_data     <= 8'd0;
      lr_len      <= 8'd0;
      line_scl    <= 1'b1;
      line_sda    <= 1'b1;
      nack_flag   <= 1'b0;
      seg_ptr     <= 4'd0;
    end else if (accept) begin
      step        <= step_next;
      bit_count   <= bit_count_next;
      shift_byte  <= shift_byte_next;
      bytes_left  <= bytes_left_next;
      delay_count <= delay_count_next;
      lr_rd       <= lr_rd_next;
      lr_reg      <= lr_reg_next;
      lr_data     <= lr_data_next;
      lr_len      <= lr_len_next;
      line_scl    <= line_scl_next;
      line_sda    <= line_sda_next;
      nack_flag   <= nack_flag_next;
      seg_ptr     <= seg_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_scl  <= line_scl_next;
      out_sda  <= line_sda_next;
      out_busy <= busy_c;
      out_rdv  <= rdv_c;
      out_rdd  <= rdd_c;
      out_rdl  <= rdl_c;
      out_nack <= nack_flag_next;
      out_done <= done_c;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.scl_out   = out_scl;
  assign rsp.sda_out   = out_sda;
  assign rsp.busy_res  = out_busy;
  assign rsp.rd_valid  = out_rdv;
  assign rsp.rd_data   = out_rdd;
  assign rsp.rd_last   = out_rdl;
  assign rsp.nack_seen = out_nack;
  assign rsp.done_res  = out_done;

`ifndef SYNTHESIS
  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_IDLE) |-> (line_scl && line_sda))
    else $error("lines not released while idle");

  a_done_released: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_done) |-> (out_scl && out_sda && out_busy))
    else $error("done without a released bus");

  a_last_has_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_rdl) |-> (out_rdv && out_busy))
    else $error("rd_last without a received byte");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (!accept) |=> $stable(step) && $stable(delay_count))
    else $error("sequencer moved without an accepted item");
`endif

endmodule
